// ===== sv/motion_mask_centroid_top_macros.svh =====
// Assertion macros shared by the motion mask centroid RTL.
// Included by mmc_back, which carries the concurrent checks; no other dependencies.
`ifndef MOTION_MASK_CENTROID_TOP_MACROS_SVH
`define MOTION_MASK_CENTROID_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mmc_pkg.sv =====
// Shared types, constants and helpers for the motion mask centroid block.
// No dependencies; used by every module of the block.
package mmc_pkg;

  // Frame limits and field widths.
  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 1024;
  localparam int COORD_W     = 10;
  localparam int CHAN_W      = 8;
  localparam int SQ_W        = 2 * CHAN_W;
  localparam int THR_W       = 18;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5000);
  localparam int SUM_W       = 30;
  localparam int CNT_W       = 21;
  localparam int Q_W         = COORD_W;
  localparam int DIV_STEPS   = Q_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Command codes carried by an input word.
  typedef enum logic {
    CMD_PIXEL  = 1'b0,
    CMD_FORGET = 1'b1
  } cmd_t;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    cmd_t               cmd;
    logic               moving;
    logic               eof;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } item_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  // True when the coordinate lies inside the configured frame.
  function automatic logic in_frame(input logic [COORD_W-1:0] row,
                                    input logic [COORD_W-1:0] col);
    in_frame = (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
  endfunction

endpackage

// ===== sv/motion_mask_centroid_top.sv =====
// Motion mask centroid top; depends on mmc_pkg, mmc_front, mmc_queue and mmc_back.
// A frame-end pixel taken from the queue starts two 10-step dividers when the frame had motion;
// the result register is loaded once they finish, or straight from ST_EMIT when it had none.
// Throughput: one word per cycle between frame ends while the queue has room; a frame end holds the
// back end through the divisions plus any wait on a held result, and the 4-entry queue can then fill.
// Reset (synchronous, rst high) clears sums, previous point and valid flags; threshold is 5000.
module motion_mask_centroid_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mmc_pkg::THR_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [mmc_pkg::CHAN_W-1:0]    diff_c0,
  input  logic [mmc_pkg::CHAN_W-1:0]    diff_c1,
  input  logic [mmc_pkg::CHAN_W-1:0]    diff_c2,
  input  logic [mmc_pkg::COORD_W-1:0]   pixel_row,
  input  logic [mmc_pkg::COORD_W-1:0]   pixel_col,
  input  logic                          end_of_frame,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [mmc_pkg::COORD_W-1:0]   centroid_row,
  output logic [mmc_pkg::COORD_W-1:0]   centroid_col,
  output logic                          had_previous,
  output logic [mmc_pkg::COORD_W-1:0]   previous_row,
  output logic [mmc_pkg::COORD_W-1:0]   previous_col
);

  mmc_pkg::queue_status_t q_status;
  mmc_pkg::item_t         push_item;
  mmc_pkg::item_t         pop_item;
  logic                   push;
  logic                   pop;

  // Front end: threshold register and pixel classification.
  mmc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .diff_c0      (diff_c0),
    .diff_c1      (diff_c1),
    .diff_c2      (diff_c2),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .end_of_frame (end_of_frame),
    .q_status     (q_status),
    .push         (push),
    .push_item    (push_item)
  );

  // Word queue between the two halves.
  mmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  // Back end: accumulation, division and result register.
  mmc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .pop_item     (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .centroid_row (centroid_row),
    .centroid_col (centroid_col),
    .had_previous (had_previous),
    .previous_row (previous_row),
    .previous_col (previous_col)
  );

endmodule

// ===== sv/mmc_front.sv =====
// Front end: holds the threshold register, accepts input words and classifies pixels.
// Depends on mmc_pkg.
module mmc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mmc_pkg::THR_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              command,
  input  logic [mmc_pkg::CHAN_W-1:0]        diff_c0,
  input  logic [mmc_pkg::CHAN_W-1:0]        diff_c1,
  input  logic [mmc_pkg::CHAN_W-1:0]        diff_c2,
  input  logic [mmc_pkg::COORD_W-1:0]       pixel_row,
  input  logic [mmc_pkg::COORD_W-1:0]       pixel_col,
  input  logic                              end_of_frame,
  input  mmc_pkg::queue_status_t            q_status,
  output logic                              push,
  output mmc_pkg::item_t                    push_item
);

  logic [mmc_pkg::THR_W-1:0] threshold;
  logic [mmc_pkg::SQ_W-1:0]  sq0, sq1, sq2;
  logic [mmc_pkg::THR_W-1:0] energy;

  // Threshold register, written through the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= mmc_pkg::THR_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  // Energy of the difference pixel: sum of the squared channels.
  assign sq0    = mmc_pkg::SQ_W'(diff_c0) * mmc_pkg::SQ_W'(diff_c0);
  assign sq1    = mmc_pkg::SQ_W'(diff_c1) * mmc_pkg::SQ_W'(diff_c1);
  assign sq2    = mmc_pkg::SQ_W'(diff_c2) * mmc_pkg::SQ_W'(diff_c2);
  assign energy = mmc_pkg::THR_W'(sq0) + mmc_pkg::THR_W'(sq1) + mmc_pkg::THR_W'(sq2);

  // Accept a word whenever the queue has room.
  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  // Classified word for the back end.
  always_comb begin
    push_item.cmd    = command ? mmc_pkg::CMD_FORGET : mmc_pkg::CMD_PIXEL;
    push_item.moving = (energy >= threshold) && mmc_pkg::in_frame(pixel_row, pixel_col);
    push_item.eof    = end_of_frame;
    push_item.row    = pixel_row;
    push_item.col    = pixel_col;
  end

endmodule

// ===== sv/mmc_queue.sv =====
// Short word queue between the front end and the back end.
// Depends on mmc_pkg.
module mmc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mmc_pkg::item_t         push_item,
  input  logic                   pop,
  output mmc_pkg::item_t         pop_item,
  output mmc_pkg::queue_status_t q_status
);

  mmc_pkg::item_t            slots [mmc_pkg::QUEUE_DEPTH];
  logic [mmc_pkg::QPTR_W:0]  wr_ptr;
  logic [mmc_pkg::QPTR_W:0]  rd_ptr;

  // Pointers carry one extra wrap bit to tell full from empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[mmc_pkg::QPTR_W-1:0]] <= push_item;
    end
  end

  assign pop_item       = slots[rd_ptr[mmc_pkg::QPTR_W-1:0]];
  assign q_status.empty = (wr_ptr == rd_ptr);
  assign q_status.full  = (wr_ptr[mmc_pkg::QPTR_W] != rd_ptr[mmc_pkg::QPTR_W]) &&
                          (wr_ptr[mmc_pkg::QPTR_W-1:0] == rd_ptr[mmc_pkg::QPTR_W-1:0]);

endmodule

// ===== sv/mmc_div.sv =====
// Restoring divider giving a saturated 10-bit quotient, one quotient bit per cycle.
// Depends on mmc_pkg.
module mmc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mmc_pkg::SUM_W-1:0]   dividend,
  input  logic [mmc_pkg::CNT_W-1:0]   divisor,
  output logic                        busy,
  output logic [mmc_pkg::Q_W-1:0]     quotient
);

  logic [mmc_pkg::STEP_W-1:0] step;
  logic [mmc_pkg::CNT_W-1:0]  rem;
  logic [mmc_pkg::CNT_W-1:0]  dvsr;
  logic [mmc_pkg::Q_W-1:0]    qd;
  logic                       sat;
  logic [mmc_pkg::CNT_W:0]    trial;
  logic                       ge;
  logic [mmc_pkg::CNT_W-1:0]  rem_next;

  // One restoring step: bring down the next dividend bit and try a subtract.
  // The remainder stays below the divisor, so the trial fits one extra bit.
  always_comb begin
    trial    = {rem, qd[mmc_pkg::Q_W-1]};
    ge       = (trial >= {1'b0, dvsr});
    rem_next = ge ? mmc_pkg::CNT_W'(trial - {1'b0, dvsr}) : trial[mmc_pkg::CNT_W-1:0];
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == mmc_pkg::STEP_W'(mmc_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath. The upper dividend bits seed the remainder; when they already
  // reach the divisor the quotient exceeds ten bits and saturates.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= mmc_pkg::CNT_W'(dividend[mmc_pkg::SUM_W-1:mmc_pkg::Q_W]);
      qd   <= dividend[mmc_pkg::Q_W-1:0];
      dvsr <= divisor;
      sat  <= (mmc_pkg::CNT_W'(dividend[mmc_pkg::SUM_W-1:mmc_pkg::Q_W]) >= divisor);
    end else if (busy) begin
      rem  <= rem_next;
      qd   <= {qd[mmc_pkg::Q_W-2:0], ge};
    end
  end

  assign quotient = sat ? '1 : qd;

endmodule

// ===== sv/mmc_back.sv =====
// Back end: accumulates moving pixels, runs the end-of-frame divisions and
// holds the result and the previous centroid. Depends on mmc_pkg, mmc_div and the macros.
`include "motion_mask_centroid_top_macros.svh"

module mmc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  mmc_pkg::queue_status_t        q_status,
  input  mmc_pkg::item_t                pop_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [mmc_pkg::COORD_W-1:0]   centroid_row,
  output logic [mmc_pkg::COORD_W-1:0]   centroid_col,
  output logic                          had_previous,
  output logic [mmc_pkg::COORD_W-1:0]   previous_row,
  output logic [mmc_pkg::COORD_W-1:0]   previous_col
);

  mmc_pkg::back_state_t        state, state_next;
  logic [mmc_pkg::SUM_W-1:0]   row_sum, row_sum_next;
  logic [mmc_pkg::SUM_W-1:0]   col_sum, col_sum_next;
  logic [mmc_pkg::CNT_W-1:0]   moving_count, moving_count_next;
  logic                        prev_valid;
  logic [mmc_pkg::COORD_W-1:0] prev_row;
  logic [mmc_pkg::COORD_W-1:0] prev_col;
  logic                        frame_found;
  logic                        is_pixel;
  logic                        is_forget;
  logic                        frame_end;
  logic                        div_start;
  logic                        out_load;
  logic                        row_busy, col_busy;
  logic [mmc_pkg::Q_W-1:0]     row_q, col_q;

  // Decode of the word at the queue head.
  assign is_pixel  = pop && (pop_item.cmd == mmc_pkg::CMD_PIXEL);
  assign is_forget = pop && (pop_item.cmd == mmc_pkg::CMD_FORGET);
  assign frame_end = is_pixel && pop_item.eof;

  // Accumulators, including the pixel that ends the frame.
  always_comb begin
    row_sum_next      = row_sum;
    col_sum_next      = col_sum;
    moving_count_next = moving_count;
    if (is_pixel && pop_item.moving) begin
      row_sum_next      = row_sum + mmc_pkg::SUM_W'(pop_item.row);
      col_sum_next      = col_sum + mmc_pkg::SUM_W'(pop_item.col);
      moving_count_next = moving_count + 1'b1;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      mmc_pkg::ST_RUN: begin
        if (frame_end) begin
          state_next = (moving_count_next != '0) ? mmc_pkg::ST_DIV : mmc_pkg::ST_EMIT;
        end
      end
      mmc_pkg::ST_DIV: begin
        if (!row_busy && !col_busy) begin
          state_next = mmc_pkg::ST_EMIT;
        end
      end
      mmc_pkg::ST_EMIT: begin
        if (out_load) begin
          state_next = mmc_pkg::ST_RUN;
        end
      end
      default: state_next = mmc_pkg::ST_RUN;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop       = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      mmc_pkg::ST_RUN:  pop      = !q_status.empty;
      mmc_pkg::ST_DIV:  pop      = 1'b0;
      mmc_pkg::ST_EMIT: out_load = !out_valid || !out_stall;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign div_start = frame_end && (moving_count_next != '0);

  // Two dividers run in lockstep for the row and the column.
  mmc_div u_div_row (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (row_sum_next),
    .divisor  (moving_count_next),
    .busy     (row_busy),
    .quotient (row_q)
  );

  mmc_div u_div_col (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (col_sum_next),
    .divisor  (moving_count_next),
    .busy     (col_busy),
    .quotient (col_q)
  );

  // Sequencer state, frame sums and previous point.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mmc_pkg::ST_RUN;
      row_sum      <= '0;
      col_sum      <= '0;
      moving_count <= '0;
      frame_found  <= 1'b0;
      prev_valid   <= 1'b0;
      prev_row     <= '0;
      prev_col     <= '0;
    end else begin
      state <= state_next;
      if (frame_end) begin
        row_sum      <= '0;
        col_sum      <= '0;
        moving_count <= '0;
        frame_found  <= (moving_count_next != '0);
      end else begin
        row_sum      <= row_sum_next;
        col_sum      <= col_sum_next;
        moving_count <= moving_count_next;
      end
      if (is_forget) begin
        prev_valid <= 1'b0;
        prev_row   <= '0;
        prev_col   <= '0;
      end else if (out_load && frame_found) begin
        prev_valid <= 1'b1;
        prev_row   <= row_q;
        prev_col   <= col_q;
      end
    end
  end

  // Output register; the back end keeps accumulating while a word waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found        <= frame_found;
      centroid_row <= frame_found ? row_q : '0;
      centroid_col <= frame_found ? col_q : '0;
      had_previous <= prev_valid;
      previous_row <= prev_row;
      previous_col <= prev_col;
    end
  end

  // Checks on the sequencer and its dividers.
  `MMC_ASSERT_NOW(a_div_lockstep, clk, rst, 1'b1, row_busy == col_busy, "dividers out of step")
  `MMC_ASSERT_NOW(a_pop_nonempty, clk, rst, pop, !q_status.empty, "pop from empty queue")
  `MMC_ASSERT_NOW(a_load_free, clk, rst, out_load, !out_valid || !out_stall, "output overwritten")
  `MMC_ASSERT_NEXT(a_prev_set, clk, rst, out_load && frame_found, prev_valid, "previous not stored")

endmodule
